// ===== rtl/skt_pkg.sv =====
`default_nettype none
package skt_pkg;

	localparam int TABLE_CAPACITY = 1024;
	localparam int HASH_BYTES = 20;

	localparam int SERVICE_W = 8;
	localparam int FIELD_W = 8;
	localparam int UPPER_W = 64;
	localparam int MIDDLE_W = 64;
	localparam int LOWER_W = 8 * HASH_BYTES - UPPER_W - MIDDLE_W;

	localparam int STATUS_W = 2;
	localparam int HANDLE_W = 10;
	localparam int POS_W = 11;

	// field order gives the key order when compared as one vector
	typedef struct packed {
		logic [SERVICE_W-1:0] service;
		logic [FIELD_W-1:0]   field_id;
		logic [UPPER_W-1:0]   hash_upper;
		logic [MIDDLE_W-1:0]  hash_middle;
		logic [LOWER_W-1:0]   hash_lower;
	} key_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND    = 2'd0,
		ST_INSERTED = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic compare;
		logic occupied;
		logic load_new;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/skt_if.sv =====
`default_nettype none
interface skt_req_if;
	logic                          valid;
	logic                          ready;
	logic [skt_pkg::SERVICE_W-1:0] service;
	logic [skt_pkg::FIELD_W-1:0]   field_id;
	logic [skt_pkg::UPPER_W-1:0]   hash_upper;
	logic [skt_pkg::MIDDLE_W-1:0]  hash_middle;
	logic [skt_pkg::LOWER_W-1:0]   hash_lower;

	modport source (output valid, service, field_id, hash_upper, hash_middle, hash_lower,
		input ready);
	modport sink (input valid, service, field_id, hash_upper, hash_middle, hash_lower,
		output ready);
endinterface

interface skt_res_if;
	logic                         valid;
	logic                         ready;
	skt_pkg::status_t             status;
	logic [skt_pkg::HANDLE_W-1:0] record_handle;
	logic [skt_pkg::POS_W-1:0]    sorted_position;
	logic [skt_pkg::POS_W-1:0]    entry_total;

	modport source (output valid, status, record_handle, sorted_position, entry_total,
		input ready);
	modport sink (input valid, status, record_handle, sorted_position, entry_total,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/skt_cell.sv =====
`default_nettype none
module skt_cell #(
	parameter int HW = 10
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  skt_pkg::key_t       req_key,
	input  skt_pkg::key_t       new_key,
	input  wire [HW-1:0]        new_handle,
	input  skt_pkg::key_t       prev_key,
	input  wire [HW-1:0]        prev_handle,
	output skt_pkg::key_t       key_q,
	output logic [HW-1:0]       handle_q,
	output logic                gt_q,
	output logic                eq_q
);

	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			key_q    <= new_key;
			handle_q <= new_handle;
		end else if (ctrl.shift) begin
			key_q    <= prev_key;
			handle_q <= prev_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctrl.compare) begin
			gt_q <= ctrl.occupied && (req_key > key_q);
			eq_q <= ctrl.occupied && (req_key == key_q);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sorted_key_table_find_or_insert.sv =====
`default_nettype none
// Sorted find-or-insert table built as a chain of key cells. When a request is
// accepted in S_IDLE, every cell compares the request against its own key and
// registers the result. In the following S_UPDATE state the registered compare
// results are encoded into the sorted position and, for a new key, every cell above
// that position takes its lower neighbor's key while the insertion cell loads the
// request. S_UPDATE waits while the previous result still sits unclaimed in the
// output register. Reset clears count, state and flags; cells need no clearing.
module sorted_key_table_find_or_insert #(
	parameter int TABLE_CAPACITY = skt_pkg::TABLE_CAPACITY
) (
	input wire         clk,
	input wire         arst_n,
	skt_req_if.sink    req,
	skt_res_if.source  res
);

	localparam int CW = $clog2(TABLE_CAPACITY + 1);
	localparam int HW = $clog2(TABLE_CAPACITY);
	localparam int POS_W = skt_pkg::POS_W;
	localparam int HANDLE_W = skt_pkg::HANDLE_W;

	skt_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q;
	skt_pkg::key_t   req_q;
	skt_pkg::key_t   in_key;

	logic [TABLE_CAPACITY-1:0] gt_vec, eq_vec, ins_vec;
	skt_pkg::key_t             cell_key [TABLE_CAPACITY];
	logic [HW-1:0]             cell_handle [TABLE_CAPACITY];

	logic          in_accept, out_free, out_load, insert_go, found, pos_hit, table_full;
	logic [CW-1:0] pos_enc, pos, count_next;
	logic [HW-1:0] found_handle;

	logic                  out_valid_q;
	skt_pkg::status_t      status_q;
	logic [HANDLE_W-1:0]   handle_out_q;
	logic [POS_W-1:0]      pos_out_q;
	logic [POS_W-1:0]      total_out_q;

	assign in_key = '{service: req.service, field_id: req.field_id,
		hash_upper: req.hash_upper, hash_middle: req.hash_middle,
		hash_lower: req.hash_lower};

	assign in_accept = req.valid && req.ready;
	assign out_free = !out_valid_q || res.ready;
	assign table_full = (count_q >= CW'(TABLE_CAPACITY));

	always_comb begin
		ins_vec      = '0;
		pos_enc      = '0;
		pos_hit      = 1'b0;
		found        = 1'b0;
		found_handle = '0;
		for (int i = 0; i < TABLE_CAPACITY; i++) begin
			ins_vec[i] = ((i == 0) ? 1'b1 : gt_vec[(i == 0) ? 0 : i - 1]) && !gt_vec[i];
			pos_enc = pos_enc | (ins_vec[i] ? CW'(i) : '0);
			pos_hit = pos_hit | ins_vec[i];
			found = found | eq_vec[i];
			found_handle = found_handle | (eq_vec[i] ? cell_handle[i] : '0);
		end
	end

	assign pos = pos_hit ? pos_enc : CW'(TABLE_CAPACITY);
	assign insert_go = out_load && !found && !table_full;
	assign count_next = insert_go ? count_q + CW'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			skt_pkg::S_IDLE: begin
				req.ready = arst_n;
				if (req.valid) begin
					state_d = skt_pkg::S_UPDATE;
				end
			end
			skt_pkg::S_UPDATE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = skt_pkg::S_IDLE;
				end
			end
			default: state_d = skt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q <= in_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_out_q   <= POS_W'(pos);
			total_out_q <= POS_W'(count_next);
			if (found) begin
				status_q     <= skt_pkg::ST_FOUND;
				handle_out_q <= HANDLE_W'(found_handle);
			end else if (table_full) begin
				status_q     <= skt_pkg::ST_FULL;
				handle_out_q <= '0;
			end else begin
				status_q     <= skt_pkg::ST_INSERTED;
				handle_out_q <= HANDLE_W'(count_q);
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.status          = status_q;
	assign res.record_handle   = handle_out_q;
	assign res.sorted_position = pos_out_q;
	assign res.entry_total     = total_out_q;

	for (genvar g = 0; g < TABLE_CAPACITY; g++) begin : g_cell
		skt_pkg::cell_ctrl_t ctrl;
		skt_pkg::key_t       prev_key;
		logic [HW-1:0]       prev_handle;

		if (g == 0) begin : g_first
			assign prev_key    = req_q;
			assign prev_handle = HW'(count_q);
			assign ctrl.shift  = 1'b0;
		end else begin : g_rest
			assign prev_key    = cell_key[g-1];
			assign prev_handle = cell_handle[g-1];
			assign ctrl.shift  = insert_go && !gt_vec[g-1];
		end

		assign ctrl.compare  = in_accept;
		assign ctrl.occupied = (CW'(g) < count_q);
		assign ctrl.load_new = insert_go && ins_vec[g];

		skt_cell #(
			.HW(HW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.req_key    (in_key),
			.new_key    (req_q),
			.new_handle (HW'(count_q)),
			.prev_key   (prev_key),
			.prev_handle(prev_handle),
			.key_q      (cell_key[g]),
			.handle_q   (cell_handle[g]),
			.gt_q       (gt_vec[g]),
			.eq_q       (eq_vec[g])
		);
	end

endmodule
`default_nettype wire
